@@ rtl/gbnms_pkg.sv @@
// shared types and constants for the greedy box nms core
`timescale 1ns / 1ps
`default_nettype none
package gbnms_pkg;

  localparam int unsigned MAX_KEPT_DEF = 64;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned AREA_W       = 32;
  localparam int unsigned THR_W        = 9;
  localparam int unsigned TOTAL_W      = 7;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  typedef struct packed {
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } cmp_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/gbnms_cell.sv @@
// one ring cell holding a kept box and its area
`timescale 1ns / 1ps
`default_nettype none
module gbnms_cell (
  input  wire                            clk,
  input  wire                            shift_en,
  input  wire                            load_en,
  input  gbnms_pkg::box_t                nb_box,
  input  wire [gbnms_pkg::AREA_W-1:0]    nb_area,
  input  gbnms_pkg::box_t                new_box,
  input  wire [gbnms_pkg::AREA_W-1:0]    new_area,
  output gbnms_pkg::box_t                box,
  output logic [gbnms_pkg::AREA_W-1:0]   area
);
  import gbnms_pkg::*;

  box_t              box_r;
  logic [AREA_W-1:0] area_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      box_r  <= nb_box;
      area_r <= nb_area;
    end else if (load_en) begin
      box_r  <= new_box;
      area_r <= new_area;
    end
  end

  assign box  = box_r;
  assign area = area_r;

endmodule
`default_nettype wire

@@ rtl/gbnms_iou.sv @@
// four-stage iou threshold compare of the probe box against one kept box
`timescale 1ns / 1ps
`default_nettype none
module gbnms_iou (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  gbnms_pkg::box_t                probe_box,
  input  wire [gbnms_pkg::AREA_W-1:0]    probe_area,
  input  gbnms_pkg::box_t                kept_box,
  input  wire [gbnms_pkg::AREA_W-1:0]    kept_area,
  input  wire [gbnms_pkg::THR_W-1:0]     thr,
  output gbnms_pkg::cmp_st_t             st
);
  import gbnms_pkg::*;

  localparam int unsigned EW  = COORD_W + 1;
  localparam int unsigned UW  = AREA_W + 1;
  localparam int unsigned LW  = AREA_W + 8;
  localparam int unsigned PW  = UW + THR_W;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [AREA_W-1:0]  karea1_r, karea2_r;
  logic [AREA_W-1:0]  inter2_r, inter3_r;
  logic [UW-1:0]      uni3_r;
  logic               hit4_r;

  logic [EW-1:0] a_l, a_r, b_l, b_r, a_t, a_b, b_t, b_b;
  logic [EW-1:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
  logic [COORD_W-1:0] ox_nxt, oy_nxt;
  logic [UW-1:0] uni_nxt;
  logic [PW-1:0] lhs, rhs;

  always_comb begin
    a_l  = {1'b0, probe_box.left};
    a_r  = {1'b0, probe_box.left} + {1'b0, probe_box.width};
    b_l  = {1'b0, kept_box.left};
    b_r  = {1'b0, kept_box.left} + {1'b0, kept_box.width};
    a_t  = {1'b0, probe_box.top};
    a_b  = {1'b0, probe_box.top} + {1'b0, probe_box.height};
    b_t  = {1'b0, kept_box.top};
    b_b  = {1'b0, kept_box.top} + {1'b0, kept_box.height};
    lo_x = (a_l > b_l) ? a_l : b_l;
    hi_x = (a_r < b_r) ? a_r : b_r;
    lo_y = (a_t > b_t) ? a_t : b_t;
    hi_y = (a_b < b_b) ? a_b : b_b;
    dx   = hi_x - lo_x;
    dy   = hi_y - lo_y;
    ox_nxt = (hi_x > lo_x) ? dx[COORD_W-1:0] : '0;
    oy_nxt = (hi_y > lo_y) ? dy[COORD_W-1:0] : '0;
    uni_nxt = {1'b0, probe_area} + {1'b0, karea2_r} - {1'b0, inter2_r};
    lhs = {{(PW-LW){1'b0}}, inter3_r, 8'b0};
    rhs = {{UW{1'b0}}, thr} * {{THR_W{1'b0}}, uni3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    karea1_r <= kept_area;
    inter2_r <= AREA_W'(ox_r) * AREA_W'(oy_r);
    karea2_r <= karea1_r;
    uni3_r   <= uni_nxt;
    inter3_r <= inter2_r;
    hit4_r   <= lhs > rhs;
  end

  assign st.hit  = v4_r & hit4_r;
  assign st.busy = v1_r | v2_r | v3_r | v4_r;

endmodule
`default_nettype wire

@@ rtl/greedy_box_nms_core.sv @@
// greedy box nms top level: ring of kept-box cells, compare pipeline, sequencer
//
//  port group | direction | handshake
//  -----------+-----------+--------------------------------------------
//  in_*       | in        | start high and busy low accepts a request
//  out_*      | out       | out_valid one-cycle strobe, always taken
//  cfg_*      | in        | cfg_wr_en writes cfg_wr_data, no wait
//
//  after the accepting edge the kept ring rotates once past the compare pipeline,
//  then the four-stage pipeline drains and the done state registers the result
//  strobe; a new request is taken in the strobe cycle
//  synchronous active-low reset empties the kept list and loads threshold 115
//  no clearing pass; the receiver cannot stall the result
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_nms_core #(
  parameter int unsigned MAX_KEPT = gbnms_pkg::MAX_KEPT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire [gbnms_pkg::COORD_W-1:0]       in_box_left,
  input  wire [gbnms_pkg::COORD_W-1:0]       in_box_top,
  input  wire [gbnms_pkg::COORD_W-1:0]       in_box_width,
  input  wire [gbnms_pkg::COORD_W-1:0]       in_box_height,
  input  wire                                in_first_of_set,
  output logic                               out_valid,
  output logic                               out_keep,
  output logic [gbnms_pkg::TOTAL_W-1:0]      out_kept_total,
  output logic                               out_store_full,
  input  wire                                cfg_wr_en,
  input  wire [gbnms_pkg::THR_W-1:0]         cfg_wr_data
);
  import gbnms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_KEPT + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_cnt_r;
  logic [THR_W-1:0]  thr_r;
  logic              sup_r;
  box_t              probe_r;
  logic [AREA_W-1:0] area_r;
  logic              out_valid_r, out_keep_r, out_full_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic              accept, shift_en, feed_valid, fin, keep_now, store_now, full_now;
  logic [CW+TOTAL_W-1:0] total_ext;
  cmp_st_t           cmp_st;

  box_t              cell_box  [MAX_KEPT];
  logic [AREA_W-1:0] cell_area [MAX_KEPT];

  assign accept = start & (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    shift_en   = 1'b0;
    feed_valid = 1'b0;
    fin        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        shift_en   = 1'b1;
        feed_valid = scan_cnt_r < count_r;
        if (scan_cnt_r == CW'(MAX_KEPT - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!cmp_st.busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    keep_now  = ~sup_r;
    store_now = fin & keep_now & (count_r < CW'(MAX_KEPT));
    full_now  = keep_now & (count_r == CW'(MAX_KEPT));
    count_nxt = store_now ? count_r + CW'(1) : count_r;
    total_ext = {{TOTAL_W{1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_cnt_r  <= '0;
      thr_r       <= THR_RESET;
      sup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin;
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (accept) begin
        sup_r      <= 1'b0;
        scan_cnt_r <= '0;
        if (in_first_of_set) count_r <= '0;
      end else begin
        if (shift_en) scan_cnt_r <= scan_cnt_r + CW'(1);
        if (cmp_st.hit) sup_r <= 1'b1;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_r.left   <= in_box_left;
      probe_r.top    <= in_box_top;
      probe_r.width  <= in_box_width;
      probe_r.height <= in_box_height;
      area_r <= AREA_W'(in_box_width) * AREA_W'(in_box_height);
    end
    if (fin) begin
      out_keep_r  <= keep_now;
      out_full_r  <= full_now;
      out_total_r <= total_ext[TOTAL_W-1:0];
    end
  end

  // kept ring, rotates toward cell 0
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbnms_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load_en  (store_now && (count_r == CW'(i))),
      .nb_box   (cell_box[(i + 1) % MAX_KEPT]),
      .nb_area  (cell_area[(i + 1) % MAX_KEPT]),
      .new_box  (probe_r),
      .new_area (area_r),
      .box      (cell_box[i]),
      .area     (cell_area[i])
    );
  end

  gbnms_iou u_iou (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (feed_valid),
    .probe_box  (probe_r),
    .probe_area (area_r),
    .kept_box   (cell_box[0]),
    .kept_area  (cell_area[0]),
    .thr        (thr_r),
    .st         (cmp_st)
  );

  assign busy           = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_keep       = out_keep_r;
  assign out_kept_total = out_total_r;
  assign out_store_full = out_full_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEPT)) else $error("kept count beyond store size");
  a_full_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep || !out_store_full)) else $error("full flag without keep");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but not busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");
  a_no_late_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !cmp_st.busy) else $error("compare still busy at decision");
`endif

endmodule
`default_nettype wire
